FILE: hw/rtl/bcc_pkg.sv
// ----------------------------------------------------------------------------
// bcc_pkg
// shared types, constants and register map of the boiling and
// condensation cell update
// ----------------------------------------------------------------------------
package bcc_pkg;

  localparam int W      = 32;   // cell field width
  localparam int HW     = 48;   // enthalpy width, q32.16
  localparam int DW     = 68;   // divisor width, enthalpy * 10 * 2^16
  localparam int NW     = 96;   // dividend width
  localparam int QW     = 32;   // quotient bits, one per divider stage
  localparam int CFG_AW = 6;
  localparam int CFG_DW = 64;

  // register map, 8 bytes per register
  localparam logic [2:0] REG_BOIL_TEMP      = 3'd0;
  localparam logic [2:0] REG_FILM_BOIL_TEMP = 3'd1;
  localparam logic [2:0] REG_FILM_COEFF     = 3'd2;
  localparam logic [2:0] REG_WET_COEFF      = 3'd3;
  localparam logic [2:0] REG_TIME_STEP      = 3'd4;
  localparam logic [2:0] REG_VAP_HEAT       = 3'd5;
  localparam logic [2:0] REG_COND_HEAT      = 3'd6;

  localparam logic [W-1:0]  RST_BOIL_TEMP      = 32'd24473190;
  localparam logic [W-1:0]  RST_FILM_BOIL_TEMP = 32'd30146560;
  localparam logic [W-1:0]  RST_FILM_COEFF     = 32'd65536;
  localparam logic [W-1:0]  RST_WET_COEFF      = 32'd65536;
  localparam logic [W-1:0]  RST_TIME_STEP      = 32'd655;
  localparam logic [HW-1:0] RST_VAP_HEAT       = 48'd65536;
  localparam logic [HW-1:0] RST_COND_HEAT      = 48'd65536;

  localparam logic [W-1:0]  TEMP_MIN      = 32'd65536;  // one kelvin
  localparam logic [W-1:0]  CP_MIN        = 32'd65536;  // heat capacity one
  localparam logic [HW-1:0] HEAT_FLOOR    = 48'd66;     // 0.001
  localparam logic [W-1:0]  DENS_MIN_ABS  = 32'd66;     // 0.001
  localparam logic [W-1:0]  DENS_MIN_EVAP = 32'd7;      // 0.0001
  localparam logic [63:0]   CAP_FLOOR     = 64'd4294967; // 0.001 in q32.32

  // reciprocals rounded down, one correction step follows
  localparam logic [W-1:0] RECIP_100 = 32'd1374389534;  // 2^37 / 100
  localparam logic [W-1:0] RECIP_10  = 32'd3435973836;  // 2^35 / 10

  typedef struct packed {
    logic [W-1:0]  boil_temp;
    logic [W-1:0]  film_boil_temp;
    logic [W-1:0]  film_coeff;
    logic [W-1:0]  wet_coeff;
    logic [W-1:0]  time_step;
    logic [HW-1:0] vaporization_heat;
    logic [HW-1:0] condensation_heat;
  } cfg_t;

  // side data that travels through a divider
  typedef struct packed {
    logic [W-1:0]  temp;
    logic [W-1:0]  rho;
    logic [W-1:0]  vapor;
    logic [W-1:0]  aux;    // heat capacity, later the moved mass
    logic [W-1:0]  limit;  // quotient ceiling
    logic [HW-1:0] heat;   // floored enthalpy of the active branch
    logic          boil;
    logic          cond;
    logic          film;
  } ctx_t;

endpackage

FILE: hw/rtl/bcc_if.sv
// ----------------------------------------------------------------------------
// bcc channel interfaces
// valid/ready channels for cell items and results
// ----------------------------------------------------------------------------
interface bcc_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] cell_temp;
  logic [31:0] cell_density;
  logic [31:0] cell_vapor;
  logic [31:0] material_cp;
  logic [31:0] reference_density;

  modport source(output valid, cell_temp, cell_density, cell_vapor, material_cp,
                 reference_density, input ready);
  modport sink(input valid, cell_temp, cell_density, cell_vapor, material_cp,
               reference_density, output ready);
endinterface

interface bcc_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] new_temp;
  logic [31:0] new_density;
  logic [31:0] new_vapor;
  logic [31:0] evaporated;
  logic [31:0] condensed;
  logic        film_boiling;

  modport source(output valid, new_temp, new_density, new_vapor, evaporated,
                 condensed, film_boiling, input ready);
  modport sink(input valid, new_temp, new_density, new_vapor, evaporated,
               condensed, film_boiling, output ready);
endinterface

FILE: hw/rtl/bcc_regs.sv
// ----------------------------------------------------------------------------
// bcc_regs
// apb configuration registers
// ----------------------------------------------------------------------------
module bcc_regs (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [bcc_pkg::CFG_AW-1:0] paddr,
  input  logic [bcc_pkg::CFG_DW-1:0] pwdata,
  output logic [bcc_pkg::CFG_DW-1:0] prdata,
  output logic                       pready,
  output bcc_pkg::cfg_t              cfg
);
  import bcc_pkg::*;

  logic       wr;
  logic [2:0] idx;

  assign pready = 1'b1;
  assign wr     = psel & penable & pwrite;
  assign idx    = paddr[CFG_AW-1:3];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.boil_temp         <= RST_BOIL_TEMP;
      cfg.film_boil_temp    <= RST_FILM_BOIL_TEMP;
      cfg.film_coeff        <= RST_FILM_COEFF;
      cfg.wet_coeff         <= RST_WET_COEFF;
      cfg.time_step         <= RST_TIME_STEP;
      cfg.vaporization_heat <= RST_VAP_HEAT;
      cfg.condensation_heat <= RST_COND_HEAT;
    end else if (wr) begin
      case (idx)
        REG_BOIL_TEMP:      cfg.boil_temp         <= pwdata[W-1:0];
        REG_FILM_BOIL_TEMP: cfg.film_boil_temp    <= pwdata[W-1:0];
        REG_FILM_COEFF:     cfg.film_coeff        <= pwdata[W-1:0];
        REG_WET_COEFF:      cfg.wet_coeff         <= pwdata[W-1:0];
        REG_TIME_STEP:      cfg.time_step         <= pwdata[W-1:0];
        REG_VAP_HEAT:       cfg.vaporization_heat <= pwdata[HW-1:0];
        REG_COND_HEAT:      cfg.condensation_heat <= pwdata[HW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_BOIL_TEMP:      prdata = CFG_DW'(cfg.boil_temp);
      REG_FILM_BOIL_TEMP: prdata = CFG_DW'(cfg.film_boil_temp);
      REG_FILM_COEFF:     prdata = CFG_DW'(cfg.film_coeff);
      REG_WET_COEFF:      prdata = CFG_DW'(cfg.wet_coeff);
      REG_TIME_STEP:      prdata = CFG_DW'(cfg.time_step);
      REG_VAP_HEAT:       prdata = CFG_DW'(cfg.vaporization_heat);
      REG_COND_HEAT:      prdata = CFG_DW'(cfg.condensation_heat);
      default:            prdata = '0;
    endcase
  end
endmodule

FILE: hw/rtl/bcc_front.sv
// ----------------------------------------------------------------------------
// bcc_front
// four stages: floors, branch choice, transfer product and mass divisor
// ----------------------------------------------------------------------------
module bcc_front (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   en,
  input  bcc_pkg::cfg_t          cfg,
  input  logic                   in_valid,
  input  logic [bcc_pkg::W-1:0]  cell_temp,
  input  logic [bcc_pkg::W-1:0]  cell_density,
  input  logic [bcc_pkg::W-1:0]  cell_vapor,
  input  logic [bcc_pkg::W-1:0]  material_cp,
  input  logic [bcc_pkg::W-1:0]  reference_density,
  output logic                   out_valid,
  output logic [bcc_pkg::NW-1:0] dividend,
  output logic [bcc_pkg::DW-1:0] divisor,
  output bcc_pkg::ctx_t          ctx
);
  import bcc_pkg::*;

  // stage a
  logic         a_valid, a_boil, a_cond, a_film;
  logic [W-1:0] a_temp, a_dens, a_vap, a_cp, a_coeff, a_dt, a_q0;
  logic [W:0]   a_x;
  // stage b
  logic         b_valid, b_boil, b_cond, b_film;
  logic [W-1:0] b_temp, b_vap, b_cp, b_rho;
  logic [63:0]  b_m;
  // stage c
  logic         c_valid, c_boil, c_cond, c_film;
  logic [W-1:0] c_temp, c_vap, c_cp, c_rho, c_q0;
  logic [W:0]   c_y;
  logic [63:0]  c_pa, c_pb;

  logic [W-1:0]  cp_f, dt, fd_raw, fd, cap;
  logic [W:0]    x, y, r100, r10, q_chk100, q_chk10;
  logic [64:0]   prod100, prod10;
  logic          boil, cond, film;
  logic [HW-1:0] vh, ch;
  logic [51:0]   ch10;

  always_comb begin
    cp_f    = (material_cp < CP_MIN) ? CP_MIN : material_cp;
    x       = {1'b0, reference_density} + 33'd50;
    prod100 = 65'(x) * 65'(RECIP_100);
    boil    = cell_temp > cfg.boil_temp;
    cond    = (cell_vapor != '0) && (cell_temp < cfg.boil_temp);
    film    = boil && (cell_temp >= cfg.film_boil_temp);
    dt      = boil ? (cell_temp - cfg.boil_temp) : (cfg.boil_temp - cell_temp);
  end

  always_comb begin
    q_chk100 = 33'(a_q0) * 33'd100;
    r100     = a_x - q_chk100;
    fd_raw   = (r100 >= 33'd100) ? (a_q0 + 32'd1) : a_q0;
    fd       = (fd_raw < DENS_MIN_ABS) ? DENS_MIN_ABS : fd_raw;
    y        = {1'b0, b_rho} + 33'd5;
    prod10   = 65'(y) * 65'(RECIP_10);
  end

  always_comb begin
    q_chk10 = 33'(c_q0) * 33'd10;
    r10     = c_y - q_chk10;
    cap     = (r10 >= 33'd10) ? (c_q0 + 32'd1) : c_q0;
    vh      = (cfg.vaporization_heat < HEAT_FLOOR) ? HEAT_FLOOR : cfg.vaporization_heat;
    ch      = (cfg.condensation_heat < HEAT_FLOOR) ? HEAT_FLOOR : cfg.condensation_heat;
    ch10    = {1'b0, ch, 3'b0} + {3'b0, ch, 1'b0};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid   <= 1'b0;
      b_valid   <= 1'b0;
      c_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      a_valid   <= in_valid;
      b_valid   <= a_valid;
      c_valid   <= b_valid;
      out_valid <= c_valid;
    end
    if (en) begin
      a_temp  <= cell_temp;
      a_dens  <= cell_density;
      a_vap   <= cell_vapor;
      a_cp    <= cp_f;
      a_x     <= x;
      a_q0    <= W'(prod100[64:37]);
      a_boil  <= boil;
      a_cond  <= cond;
      a_film  <= film;
      a_coeff <= film ? cfg.film_coeff : cfg.wet_coeff;
      a_dt    <= dt;

      b_temp <= a_temp;
      b_vap  <= a_vap;
      b_cp   <= a_cp;
      b_rho  <= (a_dens > fd) ? a_dens : fd;
      b_m    <= 64'(a_coeff) * 64'(a_dt);
      b_boil <= a_boil;
      b_cond <= a_cond;
      b_film <= a_film;

      c_temp <= b_temp;
      c_vap  <= b_vap;
      c_cp   <= b_cp;
      c_rho  <= b_rho;
      c_y    <= y;
      c_q0   <= W'(prod10[64:35]);
      c_pa   <= 64'(b_m[31:0]) * 64'(cfg.time_step);
      c_pb   <= 64'(b_m[63:32]) * 64'(cfg.time_step);
      c_boil <= b_boil;
      c_cond <= b_cond;
      c_film <= b_film;

      dividend  <= {32'd0, c_pa} + {c_pb, 32'd0};
      divisor   <= c_boil ? {4'd0, vh, 16'd0} : {ch10, 16'd0};
      ctx.temp  <= c_temp;
      ctx.rho   <= c_rho;
      ctx.vapor <= c_vap;
      ctx.aux   <= c_cp;
      ctx.limit <= c_boil ? cap : c_vap;
      ctx.heat  <= c_boil ? vh : ch;
      ctx.boil  <= c_boil;
      ctx.cond  <= c_cond;
      ctx.film  <= c_film;
    end
  end
endmodule

FILE: hw/rtl/bcc_div.sv
// ----------------------------------------------------------------------------
// bcc_div
// pipelined restoring divider, one quotient bit per stage, with a flag for
// quotients that do not fit in 32 bits
// ----------------------------------------------------------------------------
module bcc_div (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   en,
  input  logic                   in_valid,
  input  logic [bcc_pkg::NW-1:0] dividend,
  input  logic [bcc_pkg::DW-1:0] divisor,
  input  bcc_pkg::ctx_t          in_ctx,
  output logic                   out_valid,
  output logic [bcc_pkg::QW-1:0] quot,
  output logic                   sat,
  output bcc_pkg::ctx_t          out_ctx
);
  import bcc_pkg::*;

  logic [QW:0]   v;
  logic [DW-1:0] rem  [QW+1];
  logic [DW-1:0] dsr  [QW+1];
  logic [QW-1:0] low  [QW+1];
  logic [QW-1:0] q    [QW+1];
  logic          sflg [QW+1];
  ctx_t          cx   [QW+1];

  logic [DW:0]   trial  [QW];
  logic [DW-1:0] rem_nx [QW];
  logic          qbit   [QW];

  always_comb begin
    for (int i = 0; i < QW; i++) begin
      trial[i]  = {rem[i], low[i][QW-1]};
      qbit[i]   = trial[i] >= {1'b0, dsr[i]};
      rem_nx[i] = qbit[i] ? DW'(trial[i] - {1'b0, dsr[i]}) : DW'(trial[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) v <= '0;
    else if (en) v <= {v[QW-1:0], in_valid};
    if (en) begin
      rem[0]  <= DW'(dividend[NW-1:QW]);
      dsr[0]  <= divisor;
      low[0]  <= dividend[QW-1:0];
      q[0]    <= '0;
      sflg[0] <= DW'(dividend[NW-1:QW]) >= divisor;
      cx[0]   <= in_ctx;
      for (int i = 0; i < QW; i++) begin
        rem[i+1]  <= rem_nx[i];
        dsr[i+1]  <= dsr[i];
        low[i+1]  <= {low[i][QW-2:0], 1'b0};
        q[i+1]    <= {q[i][QW-2:0], qbit[i]};
        sflg[i+1] <= sflg[i];
        cx[i+1]   <= cx[i];
      end
    end
  end

  assign out_valid = v[QW];
  assign quot      = q[QW];
  assign sat       = sflg[QW];
  assign out_ctx   = cx[QW];
endmodule

FILE: hw/rtl/bcc_mid.sv
// ----------------------------------------------------------------------------
// bcc_mid
// three stages: mass update, energy products, temperature divisor
// ----------------------------------------------------------------------------
module bcc_mid (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   en,
  input  logic                   in_valid,
  input  logic [bcc_pkg::QW-1:0] quot,
  input  logic                   sat,
  input  bcc_pkg::ctx_t          in_ctx,
  output logic                   out_valid,
  output logic [bcc_pkg::NW-1:0] dividend,
  output logic [bcc_pkg::DW-1:0] divisor,
  output bcc_pkg::ctx_t          out_ctx
);
  import bcc_pkg::*;

  logic          e_valid, f_valid;
  ctx_t          e_ctx, f_ctx;
  ctx_t          e_next, f_next;
  logic [63:0]   f_e, f_plo;
  logic [HW-1:0] f_phi;

  logic [W-1:0] mass, rho_s, rho2, vap2;
  logic [W:0]   vsum, rsum;
  logic [63:0]  ef;
  logic [79:0]  num;

  always_comb begin
    mass  = sat ? in_ctx.limit : ((quot < in_ctx.limit) ? quot : in_ctx.limit);
    rho_s = in_ctx.rho - mass;
    vsum  = {1'b0, in_ctx.vapor} + {1'b0, mass};
    rsum  = {1'b0, in_ctx.rho} + {1'b0, mass};
    if (in_ctx.boil) begin
      rho2 = (rho_s < DENS_MIN_EVAP) ? DENS_MIN_EVAP : rho_s;
      vap2 = vsum[W] ? '1 : vsum[W-1:0];
    end else if (in_ctx.cond) begin
      rho2 = rsum[W] ? '1 : rsum[W-1:0];
      vap2 = in_ctx.vapor - mass;
    end else begin
      rho2 = in_ctx.rho;
      vap2 = in_ctx.vapor;
    end
  end

  always_comb begin
    e_next       = in_ctx;
    e_next.rho   = rho2;
    e_next.vapor = vap2;
    e_next.aux   = (in_ctx.boil || in_ctx.cond) ? mass : '0;
    e_next.limit = in_ctx.aux;  // heat capacity parked for one stage

    f_next       = e_ctx;
    f_next.limit = e_ctx.boil ? e_ctx.temp : ~e_ctx.temp;
    f_next.heat  = '0;
  end

  always_comb begin
    ef  = (f_e < CAP_FLOOR) ? CAP_FLOOR : f_e;
    num = {16'd0, f_plo} + {f_phi, 32'd0};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      e_valid   <= 1'b0;
      f_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      e_valid   <= in_valid;
      f_valid   <= e_valid;
      out_valid <= f_valid;
    end
    if (en) begin
      e_ctx <= e_next;

      f_ctx <= f_next;
      f_e   <= 64'(e_ctx.rho) * 64'(e_ctx.limit);
      f_plo <= 64'(e_ctx.heat[31:0]) * 64'(e_ctx.aux);
      f_phi <= HW'(e_ctx.heat[HW-1:32]) * HW'(e_ctx.aux);

      dividend <= {num, 16'd0};
      divisor  <= DW'(ef);
      out_ctx  <= f_ctx;
    end
  end
endmodule

FILE: hw/rtl/boiling_condensation_cell_update.sv
// ----------------------------------------------------------------------------
// boiling_condensation_cell_update
// per-cell boiling and condensation update, fully pipelined
// ----------------------------------------------------------------------------
//
//  channel    dir  transfer when          payload
//  cell_in    in   valid & ready          temp, density, vapor, cp, ref density
//  cell_out   out  valid & ready          temp, density, vapor, evap, cond, film
//  apb        in   psel&penable&pwrite    7 registers at 8 * index, 64 bit data
//
//  one cell per cycle while the output is not stalled; the pipe runs front,
//  mass divider, energy stages, temperature divider and output register;
//  the two 32 step dividers set the depth
//  synchronous reset clears all valid bits and loads register defaults
//  a stalled output freezes the whole pipe; in ready is high unless a result waits unaccepted
//
module boiling_condensation_cell_update (
  input  logic                       clk,
  input  logic                       rst,
  bcc_in_if.sink                     cell_in,
  bcc_out_if.source                  cell_out,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [bcc_pkg::CFG_AW-1:0] paddr,
  input  logic [bcc_pkg::CFG_DW-1:0] pwdata,
  output logic [bcc_pkg::CFG_DW-1:0] prdata,
  output logic                       pready
);
  import bcc_pkg::*;

  cfg_t cfg;
  logic en;

  // front to mass divider
  logic          fr_valid;
  logic [NW-1:0] fr_dividend;
  logic [DW-1:0] fr_divisor;
  ctx_t          fr_ctx;
  // mass divider to energy stages
  logic          d1_valid, d1_sat;
  logic [QW-1:0] d1_quot;
  ctx_t          d1_ctx;
  // energy stages to temperature divider
  logic          md_valid;
  logic [NW-1:0] md_dividend;
  logic [DW-1:0] md_divisor;
  ctx_t          md_ctx;
  // temperature divider to output
  logic          d2_valid, d2_sat;
  logic [QW-1:0] d2_quot;
  ctx_t          d2_ctx;

  logic [W-1:0] dtemp, t2;

  // whole pipe moves unless a result waits
  assign en           = ~cell_out.valid | cell_out.ready;
  assign cell_in.ready = en;

  bcc_regs u_regs (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready, .cfg
  );

  bcc_front u_front (
    .clk, .rst, .en, .cfg,
    .in_valid          (cell_in.valid),
    .cell_temp         (cell_in.cell_temp),
    .cell_density      (cell_in.cell_density),
    .cell_vapor        (cell_in.cell_vapor),
    .material_cp       (cell_in.material_cp),
    .reference_density (cell_in.reference_density),
    .out_valid         (fr_valid),
    .dividend          (fr_dividend),
    .divisor           (fr_divisor),
    .ctx               (fr_ctx)
  );

  // evaporated or condensed mass
  bcc_div u_div_mass (
    .clk, .rst, .en,
    .in_valid (fr_valid), .dividend (fr_dividend), .divisor (fr_divisor),
    .in_ctx   (fr_ctx),
    .out_valid(d1_valid), .quot (d1_quot), .sat (d1_sat), .out_ctx (d1_ctx)
  );

  bcc_mid u_mid (
    .clk, .rst, .en,
    .in_valid (d1_valid), .quot (d1_quot), .sat (d1_sat), .in_ctx (d1_ctx),
    .out_valid(md_valid), .dividend (md_dividend), .divisor (md_divisor),
    .out_ctx  (md_ctx)
  );

  // temperature drop or rise
  bcc_div u_div_temp (
    .clk, .rst, .en,
    .in_valid (md_valid), .dividend (md_dividend), .divisor (md_divisor),
    .in_ctx   (md_ctx),
    .out_valid(d2_valid), .quot (d2_quot), .sat (d2_sat), .out_ctx (d2_ctx)
  );

  always_comb begin
    // limit is temp for a drop and headroom to full scale for a rise
    dtemp = d2_sat ? d2_ctx.limit : ((d2_quot < d2_ctx.limit) ? d2_quot : d2_ctx.limit);
    if (d2_ctx.boil)      t2 = d2_ctx.temp - dtemp;
    else if (d2_ctx.cond) t2 = d2_ctx.temp + dtemp;
    else                  t2 = d2_ctx.temp;
    if (t2 < TEMP_MIN)    t2 = TEMP_MIN;
  end

  always_ff @(posedge clk) begin
    if (rst) cell_out.valid <= 1'b0;
    else if (en) cell_out.valid <= d2_valid;
    if (en) begin
      cell_out.new_temp     <= t2;
      cell_out.new_density  <= d2_ctx.rho;
      cell_out.new_vapor    <= d2_ctx.vapor;
      cell_out.evaporated   <= d2_ctx.boil ? d2_ctx.aux : '0;
      cell_out.condensed    <= d2_ctx.cond ? d2_ctx.aux : '0;
      cell_out.film_boiling <= d2_ctx.film;
    end
  end
endmodule

FILE: hw/rtl/bcc_checker.sv
// ----------------------------------------------------------------------------
// bcc_checker
// port level checks on the cell update
// ----------------------------------------------------------------------------
module bcc_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] new_temp,
  input logic [31:0] new_vapor,
  input logic [31:0] evaporated,
  input logic [31:0] condensed,
  input logic        film_boiling
);

  // a stalled result holds its temperature
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(new_temp))
    else $error("stalled result changed");

  a_temp_min: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> new_temp >= 32'd65536)
    else $error("temperature below one kelvin");

  // a cell boils or condenses, never both
  a_one_branch: assert property (@(posedge clk) disable iff (rst)
    out_valid && (evaporated != 32'd0) |-> condensed == 32'd0 && new_vapor >= evaporated)
    else $error("evaporation and condensation together");

  a_film: assert property (@(posedge clk) disable iff (rst)
    out_valid && film_boiling |-> condensed == 32'd0)
    else $error("film boiling while condensing");

endmodule

bind boiling_condensation_cell_update bcc_checker u_bcc_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (cell_out.valid),
  .out_ready    (cell_out.ready),
  .new_temp     (cell_out.new_temp),
  .new_vapor    (cell_out.new_vapor),
  .evaporated   (cell_out.evaporated),
  .condensed    (cell_out.condensed),
  .film_boiling (cell_out.film_boiling)
);

FILE: tb/boiling_condensation_cell_update_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// boiling_condensation_cell_update_test
// checks the per-cell boiling and condensation update against a predictor
// written from its fixed-point definitions, over several register settings,
// with random sender bursts and receiver stalls
// ----------------------------------------------------------------------------
module boiling_condensation_cell_update_test;
  import bcc_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int LATENCY        = 74;

  typedef struct packed {
    logic [31:0] temp;
    logic [31:0] density;
    logic [31:0] vapor;
    logic [31:0] evap;
    logic [31:0] cond;
    logic        film;
  } cell_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [CFG_AW-1:0] paddr = '0;
  logic [CFG_DW-1:0] pwdata = '0;
  logic [CFG_DW-1:0] prdata;
  logic pready;

  bcc_in_if  cell_in ();
  bcc_out_if cell_out ();

  boiling_condensation_cell_update DUT (
    .clk(clk), .rst(rst), .cell_in(cell_in.sink), .cell_out(cell_out.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #2 clk = ~clk;

  // predictor copy of the register file
  cfg_t shadow_cfg;

  cell_result_t pending_results[$];
  int mismatch_count = 0;
  int idle_cycles = 0;
  bit stall_enable = 1'b1;

  // floor(n / d) capped at limit, all exact
  function automatic logic [95:0] capped_quotient(logic [191:0] n, logic [191:0] d,
                                                  logic [95:0] limit);
    logic [191:0] q;
    q = n / d;
    return (q > limit) ? limit : q[95:0];
  endfunction

  function automatic cell_result_t predict_cell_update(logic [31:0] t_in,
      logic [31:0] dens, logic [31:0] vap_in, logic [31:0] cp_in, logic [31:0] rref);
    cell_result_t r;
    logic [63:0] t, vap, cp, floor_d, rho, heat, coeff, cap, e, mv;
    logic [191:0] power;
    t = 64'(t_in); vap = 64'(vap_in);
    cp = (cp_in < CP_MIN) ? 64'(CP_MIN) : 64'(cp_in);
    floor_d = (64'(rref) + 64'd50) / 64'd100;
    if (floor_d < DENS_MIN_ABS) floor_d = 64'(DENS_MIN_ABS);
    rho = (dens > floor_d) ? 64'(dens) : floor_d;
    r = '0;
    if (t > shadow_cfg.boil_temp) begin
      heat = (shadow_cfg.vaporization_heat < HEAT_FLOOR) ? 64'(HEAT_FLOOR)
                                                         : 64'(shadow_cfg.vaporization_heat);
      r.film = (t >= shadow_cfg.film_boil_temp);
      coeff = r.film ? 64'(shadow_cfg.film_coeff) : 64'(shadow_cfg.wet_coeff);
      cap = (rho + 64'd5) / 64'd10;
      power = 192'(coeff) * 192'(t - shadow_cfg.boil_temp) * 192'(shadow_cfg.time_step);
      mv = 64'(capped_quotient(power, 192'(heat) << 16, 96'(cap)));
      rho = rho - mv;
      if (rho < DENS_MIN_EVAP) rho = 64'(DENS_MIN_EVAP);
      vap = vap + mv;
      if (vap > 64'hFFFF_FFFF) vap = 64'hFFFF_FFFF;
      e = rho * cp;
      if (e < CAP_FLOOR) e = CAP_FLOOR;
      t = t - 64'(capped_quotient((192'(heat) * 192'(mv)) << 16, 192'(e), 96'(t)));
      r.evap = 32'(mv);
    end else if (vap != 0 && t < shadow_cfg.boil_temp) begin
      heat = (shadow_cfg.condensation_heat < HEAT_FLOOR) ? 64'(HEAT_FLOOR)
                                                         : 64'(shadow_cfg.condensation_heat);
      power = 192'(shadow_cfg.wet_coeff) * 192'(shadow_cfg.boil_temp - t)
              * 192'(shadow_cfg.time_step) / 192'd10;
      mv = 64'(capped_quotient(power, 192'(heat) << 16, 96'(vap)));
      vap = vap - mv;
      rho = rho + mv;
      if (rho > 64'hFFFF_FFFF) rho = 64'hFFFF_FFFF;
      e = rho * cp;
      if (e < CAP_FLOOR) e = CAP_FLOOR;
      t = t + 64'(capped_quotient((192'(heat) * 192'(mv)) << 16, 192'(e),
                                  96'(64'hFFFF_FFFF - t)));
      r.cond = 32'(mv);
    end
    if (t < TEMP_MIN) t = 64'(TEMP_MIN);
    r.temp = 32'(t); r.density = 32'(rho); r.vapor = 32'(vap);
    return r;
  endfunction

  // one register write, setup then access
  task automatic write_register(logic [2:0] index, logic [63:0] value);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= CFG_AW'({index, 3'b000}); pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (index)
      REG_BOIL_TEMP:      shadow_cfg.boil_temp         = value[31:0];
      REG_FILM_BOIL_TEMP: shadow_cfg.film_boil_temp    = value[31:0];
      REG_FILM_COEFF:     shadow_cfg.film_coeff        = value[31:0];
      REG_WET_COEFF:      shadow_cfg.wet_coeff         = value[31:0];
      REG_TIME_STEP:      shadow_cfg.time_step         = value[31:0];
      REG_VAP_HEAT:       shadow_cfg.vaporization_heat = value[47:0];
      REG_COND_HEAT:      shadow_cfg.condensation_heat = value[47:0];
      default: ;
    endcase
  endtask

  // sends one cell; the prediction is queued at the transfer edge
  task automatic send_cell(logic [31:0] t, logic [31:0] d, logic [31:0] v,
                           logic [31:0] cp, logic [31:0] rr);
    cell_in.valid <= 1'b1;
    cell_in.cell_temp <= t; cell_in.cell_density <= d; cell_in.cell_vapor <= v;
    cell_in.material_cp <= cp; cell_in.reference_density <= rr;
    do @(posedge clk); while (!cell_in.ready);
    pending_results.push_back(predict_cell_update(t, d, v, cp, rr));
  endtask

  // drop valid between bursts
  task automatic pause_sender(int cycles);
    cell_in.valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  task automatic drain();
    cell_in.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_field();
    case ($urandom_range(0, 5))
      0: return 32'h0;
      1: return 32'hFFFF_FFFF;
      2: return $urandom_range(0, 255);
      default: return $urandom();
    endcase
  endfunction

  // temperatures near the two thresholds reach every branch
  function automatic logic [31:0] rand_temp();
    logic [31:0] off;
    off = $urandom_range(0, 1 << 20);
    case ($urandom_range(0, 4))
      0: return shadow_cfg.boil_temp + off;
      1: return shadow_cfg.boil_temp - off;
      2: return shadow_cfg.film_boil_temp + off;
      3: return shadow_cfg.boil_temp;
      default: return rand_field();
    endcase
  endfunction

  task automatic random_cells(int count);
    int burst;
    while (count > 0) begin
      burst = $urandom_range(1, 20);
      for (int i = 0; i < burst && count > 0; i++, count--)
        send_cell(rand_temp(), rand_field(), rand_field(), rand_field(), rand_field());
      if ($urandom_range(0, 2) == 0) pause_sender($urandom_range(1, 8));
    end
  endtask

  // directed: thresholds, floors, saturations
  task automatic test_directed_cells();
    send_cell(RST_BOIL_TEMP, 32'd1000, 32'd5000, 32'd0, 32'd0);        // at boiling
    send_cell(RST_BOIL_TEMP - 1, 32'd1000, 32'd0, 32'd0, 32'd0);       // no vapor
    send_cell(RST_BOIL_TEMP - 1, 32'd1000, 32'd5000, 32'd0, 32'd0);
    send_cell(RST_BOIL_TEMP + 1, 32'd0, 32'd0, 32'd0, 32'hFFFF_FFFF);
    send_cell(RST_FILM_BOIL_TEMP - 1, 32'd65536, 32'd10, 32'd1, 32'd0);
    send_cell(RST_FILM_BOIL_TEMP, 32'd65536, 32'd10, 32'd1, 32'd0);
    send_cell(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_cell(32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFF0, 32'd0, 32'd0);
    send_cell(32'd0, 32'd0, 32'hFFFF_FFFF, 32'd0, 32'd0);
    send_cell(32'd0, 32'hFFFF_FFFF, 32'd1, 32'd0, 32'd6549);
    send_cell(32'd100, 32'd0, 32'd0, 32'd0, 32'd6550);
    drain();
  endtask

  task automatic test_heat_floors();
    write_register(REG_TIME_STEP, 64'hFFFF_FFFF);
    write_register(REG_WET_COEFF, 64'hFFFF_FFFF);
    write_register(REG_FILM_COEFF, 64'hFFFF_FFFF);
    write_register(REG_VAP_HEAT, 64'd0);
    write_register(REG_COND_HEAT, 64'd65);
    random_cells(150);
    drain();
  endtask

  task automatic test_extreme_heats();
    write_register(REG_BOIL_TEMP, 64'hFFFF_FFFF);
    write_register(REG_VAP_HEAT, 64'hFFFF_FFFF_FFFF);
    write_register(REG_COND_HEAT, 64'hFFFF_FFFF_FFFF_FFFF); // upper bits masked
    write_register(REG_TIME_STEP, 64'd1 << 20);
    random_cells(150);
    drain();
    write_register(REG_BOIL_TEMP, 64'd0);
    write_register(REG_FILM_BOIL_TEMP, 64'd0);
    write_register(REG_COND_HEAT, 64'd66);
    random_cells(150);
    drain();
  endtask

  task automatic test_random_settings();
    for (int phase = 0; phase < 5; phase++) begin
      write_register(REG_BOIL_TEMP, 64'($urandom()));
      write_register(REG_FILM_BOIL_TEMP, 64'($urandom()));
      write_register(REG_FILM_COEFF, 64'($urandom_range(0, 1 << 24)));
      write_register(REG_WET_COEFF, 64'($urandom()));
      write_register(REG_TIME_STEP, 64'($urandom_range(0, 1 << 18)));
      write_register(REG_VAP_HEAT, {$urandom_range(0, 65535), 32'($urandom())});
      write_register(REG_COND_HEAT, 64'({16'($urandom_range(0, 3)), 32'($urandom())}));
      random_cells(110);
      drain();
    end
  endtask

  // receiver stall pattern, with stall-free stretches
  always @(posedge clk) begin
    if (rst) cell_out.ready <= 1'b0;
    else if (!stall_enable) cell_out.ready <= 1'b1;
    else cell_out.ready <= ($urandom_range(0, 3) != 0);
  end

  // result checker
  always @(posedge clk) begin
    cell_result_t got, want;
    if (!rst && cell_out.valid && cell_out.ready) begin
      got = {cell_out.new_temp, cell_out.new_density, cell_out.new_vapor,
             cell_out.evaporated, cell_out.condensed, cell_out.film_boiling};
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("unexpected result %p", got);
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          mismatch_count++;
          if (mismatch_count <= 10) $display("mismatch: expected %p actual %p", want, got);
        end
      end
    end
  end

  // watchdog on cycles with no transfer
  always @(posedge clk) begin
    if (rst || (cell_in.valid && cell_in.ready) || (cell_out.valid && cell_out.ready)
        || psel)
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    cell_in.valid = 1'b0;
    cell_in.cell_temp = '0; cell_in.cell_density = '0; cell_in.cell_vapor = '0;
    cell_in.material_cp = '0; cell_in.reference_density = '0;
    shadow_cfg = {RST_BOIL_TEMP, RST_FILM_BOIL_TEMP, RST_FILM_COEFF, RST_WET_COEFF,
                  RST_TIME_STEP, RST_VAP_HEAT, RST_COND_HEAT};
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_cells();
    random_cells(150);
    drain();
    stall_enable = 1'b0;
    random_cells(100);
    drain();
    stall_enable = 1'b1;
    test_heat_floors();
    test_extreme_heats();
    test_random_settings();
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
